// File: rtl/wpp_pkg.sv
// Shared types, codes and constants of the WAV PCM16 stream parser.
`timescale 1ns / 1ps
`default_nettype none
package wpp_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  localparam logic [4:0] ERR_TRUNCATED   = 5'd0;
  localparam logic [4:0] ERR_BAD_RIFF    = 5'd1;
  localparam logic [4:0] ERR_RIFF_SIZE   = 5'd2;
  localparam logic [4:0] ERR_BAD_WAVE    = 5'd3;
  localparam logic [4:0] ERR_FMT_SMALL   = 5'd4;
  localparam logic [4:0] ERR_FMT_MISSING = 5'd5;
  localparam logic [4:0] ERR_NOT_PCM     = 5'd6;
  localparam logic [4:0] ERR_ZERO_CHAN   = 5'd7;
  localparam logic [4:0] ERR_ZERO_RATE   = 5'd8;
  localparam logic [4:0] ERR_NOT_16BIT   = 5'd9;
  localparam logic [4:0] ERR_ALIGN       = 5'd10;
  localparam logic [4:0] ERR_BYTE_RATE   = 5'd11;
  localparam logic [4:0] ERR_DATA_MISS   = 5'd12;
  localparam logic [4:0] ERR_TOO_LARGE   = 5'd13;
  localparam logic [4:0] ERR_EMPTY       = 5'd14;
  localparam logic [4:0] ERR_UNALIGNED   = 5'd15;
  localparam logic [4:0] ERR_DATA_FIRST  = 5'd16;
  localparam logic [4:0] ERR_NONE        = 5'd0;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] MAX_DATA_RESET = 32'h1000_0000;
  localparam logic [15:0] FMT_PCM        = 16'd1;
  localparam logic [15:0] FMT_BITS16     = 16'd16;
  localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;
  localparam logic [31:0] RIFF_MIN_SIZE  = 32'd4;

  typedef struct packed {
    logic       shift;
    logic       fc_clr;
    logic       size_ld;
    logic       size_sub16;
    logic       size_dec;
    logic       fmt_wr;
    logic       pad_clr;
    logic       data_wr;
    logic       mul_ld;
    logic       div_start;
    logic       emit;
    kind_e      emit_kind;
    logic [4:0] emit_err;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic       word_full;
    logic       tag_riff;
    logic       tag_wave;
    logic       tag_fmt;
    logic       tag_data;
    logic       word_lt4;
    logic       word_lt16;
    logic       word_zero;
    logic       fc_zero;
    logic       fc_odd;
    logic       fc_last;
    logic       size_zero;
    logic       size_one;
    logic       size_gt_max;
    logic       pad;
    logic       fmt_seen;
    logic       align_zero;
    logic [4:0] fmt_code;
    logic       div_done;
    logic       rem_zero;
    logic       out_busy;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/wpp_datapath.sv
// Datapath: field assembly, fmt registers, format check, remainder unit, output register.
`timescale 1ns / 1ps
`default_nettype none
module wpp_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          max_data_bytes_we_i,
  input  wire logic [31:0]   max_data_bytes_i,
  input  wire wpp_pkg::cmd_t cmd_i,
  output wpp_pkg::status_t   status_o,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         kind_o,
  output logic signed [15:0] sample_o,
  output logic [15:0]        channel_count_o,
  output logic [31:0]        rate_hz_o,
  output logic [4:0]         error_code_o,
  output logic               last_o
);
  import wpp_pkg::*;

  logic [3:0]  fc_q, fc_d;
  logic [31:0] shift_q;
  logic [31:0] size_q;
  logic        pad_q, fmt_seen_q;
  logic [31:0] max_q;
  logic [15:0] fmt_format_q, fmt_channels_q, fmt_align_q, fmt_bits_q;
  logic [31:0] fmt_rate_q, fmt_byte_rate_q;
  logic [7:0]  low_q;
  logic [31:0] prod_q;
  logic [15:0] rem_q;
  logic [31:0] dsh_q;
  logic [4:0]  dcnt_q;
  logic        drun_q;
  logic [16:0] rem_try;
  logic [15:0] rem_nx;
  logic [31:0] word_nx;
  logic        out_valid_q, pend_done_q, out_free;
  logic [4:0]  fmt_code;
  logic [15:0] want_align;

  assign word_nx = {data_byte_i, shift_q[31:8]};

  always_comb begin
    fc_d = fc_q;
    if (cmd_i.fc_clr) begin
      fc_d = '0;
    end else if (cmd_i.shift) begin
      fc_d = (fc_q == 4'd3) ? 4'd0 : fc_q + 4'd1;
    end else if (cmd_i.fmt_wr) begin
      fc_d = fc_q + 4'd1;
    end else if (cmd_i.data_wr) begin
      fc_d = {3'b000, ~fc_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q       <= '0;
      pad_q      <= 1'b0;
      fmt_seen_q <= 1'b0;
      max_q      <= MAX_DATA_RESET;
    end else begin
      fc_q <= fc_d;
      if (max_data_bytes_we_i) begin
        max_q <= max_data_bytes_i;
      end
      if (cmd_i.size_ld) begin
        pad_q <= word_nx[0];
      end else if (cmd_i.pad_clr) begin
        pad_q <= 1'b0;
      end
      if (cmd_i.fmt_wr && fc_q == 4'd15) begin
        fmt_seen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      shift_q <= word_nx;
    end
    if (cmd_i.size_ld) begin
      size_q <= cmd_i.size_sub16 ? word_nx - FMT_MIN_SIZE : word_nx;
    end else if (cmd_i.size_dec || cmd_i.data_wr) begin
      size_q <= size_q - 32'd1;
    end
    if (cmd_i.data_wr && !fc_q[0]) begin
      low_q <= data_byte_i;
    end
    if (cmd_i.fmt_wr) begin
      case (fc_q)
        4'd0:    fmt_format_q[7:0]     <= data_byte_i;
        4'd1:    fmt_format_q[15:8]    <= data_byte_i;
        4'd2:    fmt_channels_q[7:0]   <= data_byte_i;
        4'd3:    fmt_channels_q[15:8]  <= data_byte_i;
        4'd4:    fmt_rate_q[7:0]       <= data_byte_i;
        4'd5:    fmt_rate_q[15:8]      <= data_byte_i;
        4'd6:    fmt_rate_q[23:16]     <= data_byte_i;
        4'd7:    fmt_rate_q[31:24]     <= data_byte_i;
        4'd8:    fmt_byte_rate_q[7:0]  <= data_byte_i;
        4'd9:    fmt_byte_rate_q[15:8] <= data_byte_i;
        4'd10:   fmt_byte_rate_q[23:16] <= data_byte_i;
        4'd11:   fmt_byte_rate_q[31:24] <= data_byte_i;
        4'd12:   fmt_align_q[7:0]      <= data_byte_i;
        4'd13:   fmt_align_q[15:8]     <= data_byte_i;
        4'd14:   fmt_bits_q[7:0]       <= data_byte_i;
        default: fmt_bits_q[15:8]      <= data_byte_i;
      endcase
    end
    if (cmd_i.mul_ld) begin
      prod_q <= fmt_rate_q * {16'd0, fmt_align_q};
    end
  end

  // format check, against the byte-rate product registered in S_MUL
  assign want_align = {fmt_channels_q[14:0], 1'b0};
  always_comb begin
    if (fmt_format_q != FMT_PCM) begin
      fmt_code = ERR_NOT_PCM;
    end else if (fmt_channels_q == '0) begin
      fmt_code = ERR_ZERO_CHAN;
    end else if (fmt_rate_q == '0) begin
      fmt_code = ERR_ZERO_RATE;
    end else if (fmt_bits_q != FMT_BITS16) begin
      fmt_code = ERR_NOT_16BIT;
    end else if (fmt_align_q != want_align) begin
      fmt_code = ERR_ALIGN;
    end else if (fmt_byte_rate_q != prod_q) begin
      fmt_code = ERR_BYTE_RATE;
    end else begin
      fmt_code = ERR_NONE;
    end
  end

  // restoring remainder of size by block align, one bit per cycle
  assign rem_try = {rem_q, dsh_q[31]};
  assign rem_nx  = (rem_try >= {1'b0, fmt_align_q}) ?
                   16'(rem_try - {1'b0, fmt_align_q}) : rem_try[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drun_q <= 1'b0;
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      drun_q <= 1'b1;
      dcnt_q <= '0;
    end else if (drun_q) begin
      dcnt_q <= dcnt_q + 5'd1;
      if (dcnt_q == 5'd31) begin
        drun_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      dsh_q <= size_q;
    end else if (drun_q) begin
      rem_q <= rem_nx;
      dsh_q <= {dsh_q[30:0], 1'b0};
    end
  end

  // output register with a held done request behind the final sample
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_done_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
      pend_done_q <= cmd_i.emit_last;
    end else if (pend_done_q && out_free) begin
      out_valid_q <= 1'b1;
      pend_done_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_o          <= cmd_i.emit_kind;
      sample_o        <= (cmd_i.emit_kind == KIND_SAMPLE) ? {data_byte_i, low_q} : '0;
      channel_count_o <= (cmd_i.emit_kind == KIND_FORMAT) ? fmt_channels_q : '0;
      rate_hz_o       <= (cmd_i.emit_kind == KIND_FORMAT) ? fmt_rate_q : '0;
      error_code_o    <= cmd_i.emit_err;
      last_o          <= cmd_i.emit_last;
    end else if (pend_done_q && out_free) begin
      kind_o          <= KIND_DONE;
      sample_o        <= '0;
      channel_count_o <= '0;
      rate_hz_o       <= '0;
      error_code_o    <= ERR_NONE;
      last_o          <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.word_full   = (fc_q == 4'd3);
    status_o.tag_riff    = (word_nx == TAG_RIFF);
    status_o.tag_wave    = (word_nx == TAG_WAVE);
    status_o.tag_fmt     = (word_nx == TAG_FMT);
    status_o.tag_data    = (word_nx == TAG_DATA);
    status_o.word_lt4    = (word_nx < RIFF_MIN_SIZE);
    status_o.word_lt16   = (word_nx < FMT_MIN_SIZE);
    status_o.word_zero   = (word_nx == '0);
    status_o.fc_zero     = (fc_q == '0);
    status_o.fc_odd      = fc_q[0];
    status_o.fc_last     = (fc_q == 4'd15);
    status_o.size_zero   = (size_q == '0);
    status_o.size_one    = (size_q == 32'd1);
    status_o.size_gt_max = (size_q > max_q);
    status_o.pad         = pad_q;
    status_o.fmt_seen    = fmt_seen_q;
    status_o.align_zero  = (fmt_align_q == '0);
    status_o.fmt_code    = fmt_code;
    status_o.div_done    = drun_q && (dcnt_q == 5'd31);
    status_o.rem_zero    = (rem_nx == '0);
    status_o.out_busy    = (out_valid_q && out_stall_i) || pend_done_q;
  end

endmodule
`default_nettype wire

// File: rtl/wpp_ctrl.sv
// Controller: parse phase state machine issuing datapath commands.
`timescale 1ns / 1ps
`default_nettype none
module wpp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             is_end_i,
  input  wire wpp_pkg::status_t status_i,
  output wpp_pkg::cmd_t         cmd_o
);
  import wpp_pkg::*;

  typedef enum logic [14:0] {
    S_RIFF_TAG   = 15'b000000000000001,
    S_RIFF_SIZE  = 15'b000000000000010,
    S_WAVE_TAG   = 15'b000000000000100,
    S_CHUNK_ID   = 15'b000000000001000,
    S_SIZE_FMT   = 15'b000000000010000,
    S_SIZE_DATA  = 15'b000000000100000,
    S_SIZE_OTHER = 15'b000000001000000,
    S_FMT_BODY   = 15'b000000010000000,
    S_SKIP       = 15'b000000100000000,
    S_PAD        = 15'b000001000000000,
    S_DATA       = 15'b000010000000000,
    S_MUL        = 15'b000100000000000,
    S_EVAL       = 15'b001000000000000,
    S_DIV        = 15'b010000000000000,
    S_FINISHED   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   mode_end_q, mode_end_d;
  logic   takes, accept;

  assign takes = !(state_q == S_MUL || state_q == S_EVAL || state_q == S_DIV);
  assign in_stall_o = !takes || status_i.out_busy;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    mode_end_d = mode_end_q;
    if (accept && is_end_i && state_q != S_FINISHED) begin
      cmd_o.emit      = 1'b1;
      cmd_o.emit_kind = KIND_ERROR;
      cmd_o.emit_err  = ERR_TRUNCATED;
      state_d         = S_FINISHED;
      if (state_q == S_CHUNK_ID && status_i.fc_zero) begin
        if (!status_i.fmt_seen) begin
          cmd_o.emit_err = ERR_FMT_MISSING;
        end else begin
          cmd_o.emit = 1'b0;
          mode_end_d = 1'b1;
          state_d    = S_MUL;
        end
      end
    end else begin
      case (state_q)
        S_RIFF_TAG, S_RIFF_SIZE, S_WAVE_TAG, S_CHUNK_ID,
        S_SIZE_FMT, S_SIZE_DATA, S_SIZE_OTHER: begin
          if (accept) begin
            cmd_o.shift = 1'b1;
            if (status_i.word_full) begin
              cmd_o.emit_kind = KIND_ERROR;
              case (state_q)
                S_RIFF_TAG: begin
                  cmd_o.emit     = !status_i.tag_riff;
                  cmd_o.emit_err = ERR_BAD_RIFF;
                  state_d        = status_i.tag_riff ? S_RIFF_SIZE : S_FINISHED;
                end
                S_RIFF_SIZE: begin
                  cmd_o.emit     = status_i.word_lt4;
                  cmd_o.emit_err = ERR_RIFF_SIZE;
                  state_d        = status_i.word_lt4 ? S_FINISHED : S_WAVE_TAG;
                end
                S_WAVE_TAG: begin
                  cmd_o.emit     = !status_i.tag_wave;
                  cmd_o.emit_err = ERR_BAD_WAVE;
                  state_d        = status_i.tag_wave ? S_CHUNK_ID : S_FINISHED;
                end
                S_CHUNK_ID: begin
                  state_d = status_i.tag_fmt  ? S_SIZE_FMT :
                            status_i.tag_data ? S_SIZE_DATA : S_SIZE_OTHER;
                end
                S_SIZE_FMT: begin
                  if (status_i.word_lt16) begin
                    cmd_o.emit     = 1'b1;
                    cmd_o.emit_err = ERR_FMT_SMALL;
                    state_d        = S_FINISHED;
                  end else begin
                    cmd_o.size_ld    = 1'b1;
                    cmd_o.size_sub16 = 1'b1;
                    state_d          = S_FMT_BODY;
                  end
                end
                S_SIZE_OTHER: begin
                  cmd_o.size_ld = 1'b1;
                  state_d       = status_i.word_zero ? S_CHUNK_ID : S_SKIP;
                end
                default: begin
                  cmd_o.size_ld = 1'b1;
                  mode_end_d    = 1'b0;
                  state_d       = S_MUL;
                end
              endcase
            end
          end
        end
        S_FMT_BODY: begin
          if (accept) begin
            cmd_o.fmt_wr = 1'b1;
            if (status_i.fc_last) begin
              if (status_i.size_zero) begin
                state_d = status_i.pad ? S_PAD : S_CHUNK_ID;
              end else begin
                state_d = S_SKIP;
              end
            end
          end
        end
        S_SKIP: begin
          if (accept) begin
            cmd_o.size_dec = 1'b1;
            if (status_i.size_one) begin
              cmd_o.fc_clr = 1'b1;
              state_d      = status_i.pad ? S_PAD : S_CHUNK_ID;
            end
          end
        end
        S_PAD: begin
          if (accept) begin
            cmd_o.pad_clr = 1'b1;
            cmd_o.fc_clr  = 1'b1;
            state_d       = S_CHUNK_ID;
          end
        end
        S_DATA: begin
          if (accept) begin
            cmd_o.data_wr = 1'b1;
            if (status_i.fc_odd) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = KIND_SAMPLE;
              cmd_o.emit_last = status_i.size_one;
              if (status_i.size_one) begin
                state_d = S_FINISHED;
              end
            end
          end
        end
        S_MUL: begin
          cmd_o.mul_ld = 1'b1;
          state_d      = S_EVAL;
        end
        S_EVAL: begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = KIND_ERROR;
          state_d         = S_FINISHED;
          if (mode_end_q) begin
            cmd_o.emit_err = (status_i.fmt_code != ERR_NONE) ? status_i.fmt_code
                                                             : ERR_DATA_MISS;
          end else if (status_i.size_gt_max) begin
            cmd_o.emit_err = ERR_TOO_LARGE;
          end else if (!status_i.fmt_seen) begin
            cmd_o.emit_err = ERR_DATA_FIRST;
          end else if (status_i.fmt_code != ERR_NONE) begin
            cmd_o.emit_err = status_i.fmt_code;
          end else if (status_i.size_zero) begin
            cmd_o.emit_err = ERR_EMPTY;
          end else if (status_i.align_zero) begin
            cmd_o.emit_err = ERR_UNALIGNED;
          end else begin
            cmd_o.emit      = 1'b0;
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end
        S_DIV: begin
          if (status_i.div_done) begin
            cmd_o.emit = 1'b1;
            if (status_i.rem_zero) begin
              cmd_o.emit_kind = KIND_FORMAT;
              state_d         = S_DATA;
            end else begin
              cmd_o.emit_kind = KIND_ERROR;
              cmd_o.emit_err  = ERR_UNALIGNED;
              state_d         = S_FINISHED;
            end
          end
        end
        default: begin
          state_d = S_FINISHED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_RIFF_TAG;
      mode_end_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_end_q <= mode_end_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/wav_pcm16_stream_parser.sv
// Top level of the WAV PCM16 stream parser: controller plus datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | data_byte_i, is_end_i
//  out     | source    | out_valid_o / out_stall_i | kind_o, sample_o, channel_count_o,
//          |           |                        | rate_hz_o, error_code_o, last_o
//  config  | sink      | max_data_bytes_we_i    | max_data_bytes_i
//
// One byte request per cycle while the output register is free or being drained and no done
// is held; input stalls after the data chunk header for the byte-rate multiply, the check
// and the bit-serial remainder by block align.
// An end request between chunks after fmt also stalls for the multiply and the check.
// The final sample and done leave as two requests; input stalls until done is out.
// Reset (asynchronous, active low) returns to the RIFF tag; limit = 256 MiB.
`timescale 1ns / 1ps
`default_nettype none
module wav_pcm16_stream_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          is_end_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         kind_o,
  output logic signed [15:0] sample_o,
  output logic [15:0]        channel_count_o,
  output logic [31:0]        rate_hz_o,
  output logic [4:0]         error_code_o,
  output logic               last_o,
  input  wire logic          max_data_bytes_we_i,
  input  wire logic [31:0]   max_data_bytes_i
);
  import wpp_pkg::*;

  cmd_t    cmd;
  status_t status;

  wpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .is_end_i   (is_end_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wpp_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .data_byte_i         (data_byte_i),
    .max_data_bytes_we_i (max_data_bytes_we_i),
    .max_data_bytes_i    (max_data_bytes_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .kind_o              (kind_o),
    .sample_o            (sample_o),
    .channel_count_o     (channel_count_o),
    .rate_hz_o           (rate_hz_o),
    .error_code_o        (error_code_o),
    .last_o              (last_o)
  );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for the WAV PCM16 stream parser: one randomized WAV stream, checked per result.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import wpp_pkg::*;

  // Parser phases, mirrored in the testbench's own scoreboard model
  typedef enum logic [3:0] {
    P_RIFF, P_RSIZE, P_WAVE, P_CID, P_SZFMT, P_SZDATA, P_SZOTH,
    P_FMTB, P_SKIP, P_PAD, P_DATA, P_OVER
  } parse_ph_e;

  // How the stream ends; picked once per run by the seed
  typedef enum logic [2:0] {
    END_CLEAN, END_TRUNC, END_NO_DATA, END_TOO_BIG, END_BAD_FMT,
    END_SIZE_BAD, END_DATA_FIRST, END_HEADER
  } finish_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] sample;
    logic [15:0]        chans;
    logic [31:0]        rate;
    logic [4:0]         err;
    logic               last;
  } parse_out_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;   // covers the data header check

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          data_byte_i = '0;
  logic                is_end_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          kind_o;
  logic signed [15:0]  sample_o;
  logic [15:0]         channel_count_o;
  logic [31:0]         rate_hz_o;
  logic [4:0]          error_code_o;
  logic                last_o;
  logic                max_data_bytes_we_i = 1'b0;
  logic [31:0]         max_data_bytes_i = '0;

  wav_pcm16_stream_parser dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .is_end_i,
    .out_valid_o, .out_stall_i, .kind_o, .sample_o, .channel_count_o,
    .rate_hz_o, .error_code_o, .last_o, .max_data_bytes_we_i, .max_data_bytes_i
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Scoreboard model state
  // ---------------------------------------------------------------------------
  parse_ph_e   ph;
  logic [31:0] cnt, word, csize, max_bytes;
  logic [15:0] f_fmt, f_ch, f_align, f_bits;
  logic [31:0] f_rate, f_brate;
  logic [7:0]  low_b;
  logic        fmt_seen, pad_pend;

  parse_out_t  expected_q[$];
  int          err_cnt = 0;
  bit          calm = 0;          // when set, neither side idles
  finish_e     ending;
  int          early_sub;

  function automatic parse_out_t mk(kind_e k, logic [15:0] s, logic [15:0] c,
                                    logic [31:0] r, logic [4:0] e, logic l);
    parse_out_t o;
    o.kind = k; o.sample = s; o.chans = c; o.rate = r; o.err = e; o.last = l;
    return o;
  endfunction

  // queue one expected result behind the ones already waiting
  task automatic add_expected(parse_out_t o);
    expected_q = {expected_q, o};
  endtask

  function automatic logic [4:0] fmt_verdict();
    logic [15:0] want_align;
    logic [31:0] want_rate;
    if (f_fmt != FMT_PCM) return ERR_NOT_PCM;
    if (f_ch == 0) return ERR_ZERO_CHAN;
    if (f_rate == 0) return ERR_ZERO_RATE;
    if (f_bits != FMT_BITS16) return ERR_NOT_16BIT;
    want_align = f_ch * 16'd2;
    if (f_align != want_align) return ERR_ALIGN;
    want_rate = f_rate * {16'd0, f_align};
    if (f_brate != want_rate) return ERR_BYTE_RATE;
    return ERR_NONE;
  endfunction

  task automatic raise_error(logic [4:0] code);
    add_expected(mk(KIND_ERROR, '0, '0, '0, code, 1'b0));
    ph = P_OVER;
  endtask

  task automatic close_chunk();
    cnt = 0;
    ph = pad_pend ? P_PAD : P_CID;
  endtask

  // Advance the model by one accepted request, queueing the results it causes
  task automatic model_request(logic [7:0] b, logic fin);
    logic [4:0]  code;
    logic [31:0] v;
    if (ph == P_OVER) return;
    if (fin) begin
      if (ph == P_CID && cnt == 0) begin
        code = fmt_verdict();
        if (!fmt_seen) raise_error(ERR_FMT_MISSING);
        else raise_error(code != ERR_NONE ? code : ERR_DATA_MISS);
      end else begin
        raise_error(ERR_TRUNCATED);
      end
      return;
    end
    if (ph <= P_SZOTH) begin
      word = {b, word[31:8]};
      cnt++;
      if (cnt < 4) return;
      cnt = 0;
      v = word;
      case (ph)
        P_RIFF:  if (v != TAG_RIFF) raise_error(ERR_BAD_RIFF); else ph = P_RSIZE;
        P_RSIZE: if (v < RIFF_MIN_SIZE) raise_error(ERR_RIFF_SIZE); else ph = P_WAVE;
        P_WAVE:  if (v != TAG_WAVE) raise_error(ERR_BAD_WAVE); else ph = P_CID;
        P_CID:   ph = (v == TAG_FMT) ? P_SZFMT : (v == TAG_DATA) ? P_SZDATA : P_SZOTH;
        P_SZFMT: begin
          if (v < FMT_MIN_SIZE) begin
            raise_error(ERR_FMT_SMALL);
          end else begin
            csize = v - 32'd16;
            pad_pend = v[0];
            ph = P_FMTB;
          end
        end
        P_SZOTH: begin
          csize = v;
          pad_pend = v[0];
          if (v == 0) close_chunk(); else ph = P_SKIP;
        end
        default: begin  // data chunk header
          code = fmt_verdict();
          if (v > max_bytes) raise_error(ERR_TOO_LARGE);
          else if (!fmt_seen) raise_error(ERR_DATA_FIRST);
          else if (code != ERR_NONE) raise_error(code);
          else if (v == 0) raise_error(ERR_EMPTY);
          else if (f_align == 0 || (v % f_align) != 0) raise_error(ERR_UNALIGNED);
          else begin
            csize = v;
            ph = P_DATA;
            add_expected(mk(KIND_FORMAT, '0, f_ch, f_rate, ERR_NONE, 1'b0));
          end
        end
      endcase
      return;
    end
    case (ph)
      P_FMTB: begin
        case (cnt[3:0])
          4'd0:  f_fmt = {8'd0, b};
          4'd1:  f_fmt[15:8] = b;
          4'd2:  f_ch = {8'd0, b};
          4'd3:  f_ch[15:8] = b;
          4'd4:  f_rate = {24'd0, b};
          4'd5:  f_rate[15:8] = b;
          4'd6:  f_rate[23:16] = b;
          4'd7:  f_rate[31:24] = b;
          4'd8:  f_brate = {24'd0, b};
          4'd9:  f_brate[15:8] = b;
          4'd10: f_brate[23:16] = b;
          4'd11: f_brate[31:24] = b;
          4'd12: f_align = {8'd0, b};
          4'd13: f_align[15:8] = b;
          4'd14: f_bits = {8'd0, b};
          default: f_bits[15:8] = b;
        endcase
        cnt++;
        if (cnt >= 16) begin
          fmt_seen = 1'b1;
          cnt = 0;
          if (csize == 0) close_chunk(); else ph = P_SKIP;
        end
      end
      P_SKIP: begin
        csize--;
        if (csize == 0) close_chunk();
      end
      P_PAD: begin
        pad_pend = 1'b0;
        ph = P_CID;
        cnt = 0;
      end
      default: begin  // sample bytes
        csize--;
        if (!cnt[0]) begin
          low_b = b;
          cnt = 1;
        end else begin
          cnt = 0;
          if (csize == 0) begin
            add_expected(mk(KIND_SAMPLE, {b, low_b}, '0, '0, ERR_NONE, 1'b1));
            add_expected(mk(KIND_DONE, '0, '0, '0, ERR_NONE, 1'b0));
            ph = P_OVER;
          end else begin
            add_expected(mk(KIND_SAMPLE, {b, low_b}, '0, '0, ERR_NONE, 1'b0));
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Idling, driving and checking
  // ---------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Send one request; valid stays high across back-to-back requests
  task automatic send_req(logic [7:0] b, logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    is_end_i    <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_request(b, fin);
  endtask

  task automatic send_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) send_req(w[8*i +: 8], 1'b0);
  endtask

  task automatic send_fmt(logic [15:0] fm, logic [15:0] ch, logic [31:0] rate,
                          logic [31:0] brate, logic [15:0] align, logic [15:0] bits,
                          int extra);
    logic [31:0] size;
    size = 32'd16 + 32'(extra);
    send_word(TAG_FMT);
    send_word(size);
    send_req(fm[7:0], 1'b0); send_req(fm[15:8], 1'b0);
    send_req(ch[7:0], 1'b0); send_req(ch[15:8], 1'b0);
    send_word(rate);
    send_word(brate);
    send_req(align[7:0], 1'b0); send_req(align[15:8], 1'b0);
    send_req(bits[7:0], 1'b0); send_req(bits[15:8], 1'b0);
    repeat (extra) send_req(8'($urandom), 1'b0);
    if (size[0]) send_req(8'($urandom), 1'b0);
  endtask

  task automatic send_other_chunk(int size);
    logic [31:0] id;
    id = $urandom;
    while (id == TAG_FMT || id == TAG_DATA) id = $urandom;
    send_word(id);
    send_word(32'(size));
    repeat (size) send_req(8'($urandom), 1'b0);
    if (size % 2) send_req(8'($urandom), 1'b0);
  endtask

  // Stop sending, let every expected result arrive and the block settle, then write
  task automatic write_max_bytes(logic [31:0] v);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    max_data_bytes_we_i <= 1'b1;
    max_data_bytes_i    <= v;
    @(posedge clk_i);
    max_data_bytes_we_i <= 1'b0;
    max_bytes = v;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  // Random output back-pressure
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left  <= pick_gap();
    end
  end

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk_i) begin
    parse_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(kind_o), 32'd0);
      end else begin
        e = expected_q.pop_front();
        if (kind_o != e.kind) report_mismatch("kind", 32'(kind_o), 32'(e.kind));
        if (sample_o != e.sample) report_mismatch("sample", 32'(sample_o), 32'(e.sample));
        if (channel_count_o != e.chans)
          report_mismatch("channels", 32'(channel_count_o), 32'(e.chans));
        if (rate_hz_o != e.rate) report_mismatch("rate", rate_hz_o, e.rate);
        if (error_code_o != e.err)
          report_mismatch("error code", 32'(error_code_o), 32'(e.err));
        if (last_o != e.last) report_mismatch("last", 32'(last_o), 32'(e.last));
      end
    end
  end

  // Watchdog: too long without any request or result moving
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // RIFF tag, RIFF size and WAVE tag; header errors broken in on purpose
  task automatic test_riff_header();
    logic [31:0] w;
    calm = 1;
    w = TAG_RIFF;
    if (ending == END_HEADER && early_sub == 0) w = TAG_RIFF ^ (32'd1 << $urandom_range(31));
    send_word(w);
    w = $urandom_range(2) == 0 ? 32'hFFFF_FFFF : $urandom | 32'd4;
    if (ending == END_HEADER && early_sub == 1) w = $urandom_range(3);
    send_word(w);
    w = TAG_WAVE;
    if (ending == END_HEADER && early_sub == 2) w = TAG_WAVE ^ (32'd1 << $urandom_range(31));
    send_word(w);
    calm = 0;
  endtask

  // Unknown chunks (empty, odd with pad), junk fmt chunks later overwritten
  task automatic test_chunk_walk();
    bit no_fmt;
    no_fmt = (ending == END_DATA_FIRST || ending == END_HEADER);
    send_other_chunk(0);
    send_other_chunk(1);
    for (int i = 0; i < 6; i++) begin
      if (!no_fmt && $urandom_range(1)) begin
        send_fmt(16'($urandom), 16'($urandom), $urandom, $urandom, 16'($urandom),
                 16'($urandom), $urandom_range(5));
      end else begin
        send_other_chunk($urandom_range(4) == 0 ? $urandom_range(60) : $urandom_range(9));
      end
    end
    if (ending == END_HEADER && early_sub == 3) begin
      send_word(TAG_FMT);
      send_word($urandom_range(15));
    end
    if (ending == END_HEADER && early_sub == 4) send_req(8'($urandom), 1'b1);
  endtask

  // Final fmt, limit register, data header and the samples
  task automatic test_data_chunk();
    logic [15:0] ch, align;
    logic [31:0] rate, size, brate;
    int          nbytes, cut;
    ch = $urandom_range(3) == 0 ? 16'($urandom_range(8, 3)) : 16'($urandom_range(2, 1));
    if (ending == END_SIZE_BAD && $urandom_range(1)) ch = 16'h8000;  // align wraps to 0
    rate = $urandom_range(3) == 0 ? $urandom : $urandom_range(96000, 8000);
    if (rate == 0) rate = 1;
    align = ch * 16'd2;
    brate = rate * {16'd0, align};
    if (ending == END_BAD_FMT) begin
      case ($urandom_range(5))
        0: send_fmt(16'($urandom_range(65535, 2)), ch, rate, brate, align, FMT_BITS16, 0);
        1: send_fmt(FMT_PCM, 16'd0, rate, 32'd0, 16'd0, FMT_BITS16, 0);
        2: send_fmt(FMT_PCM, ch, 32'd0, 32'd0, align, FMT_BITS16, 0);
        3: send_fmt(FMT_PCM, ch, rate, brate, align, 16'd8, 0);
        4: send_fmt(FMT_PCM, ch, rate, brate, align + 16'd2, FMT_BITS16, 0);
        default: send_fmt(FMT_PCM, ch, rate, brate + 32'd1, align, FMT_BITS16, 0);
      endcase
    end else if (ending != END_DATA_FIRST && ending != END_HEADER) begin
      send_fmt(FMT_PCM, ch, rate, brate, align, FMT_BITS16, $urandom_range(3));
    end
    if (ending == END_NO_DATA) begin
      send_req(8'($urandom), 1'b1);
      return;
    end
    // roughly 560 data bytes, whole frames
    size = (align == 0) ? 32'd560 : (32'd560 / align) * align;
    if (ending == END_SIZE_BAD)
      size = (align == 0 || $urandom_range(1)) ? 32'd0 : size + $urandom_range(align - 1, 1);
    case ($urandom_range(2))
      0: write_max_bytes(size);
      1: write_max_bytes(32'hFFFF_FFFF);
      default: write_max_bytes(size + $urandom_range(1000));
    endcase
    if (ending == END_TOO_BIG) write_max_bytes(size - 1);
    send_word(TAG_DATA);
    send_word(size);
    nbytes = int'(size);
    cut = (ending == END_TRUNC) ? $urandom_range(nbytes - 1) : nbytes;
    for (int i = 0; i < cut; i++) begin
      case (i)  // samples -32768, 127 and -1 lead the data
        0, 3: send_req(8'h00, 1'b0);
        1:    send_req(8'h80, 1'b0);
        2:    send_req(8'h7F, 1'b0);
        4, 5: send_req(8'hFF, 1'b0);
        default: send_req(8'($urandom), 1'b0);
      endcase
    end
    if (ending == END_TRUNC) send_req(8'($urandom), 1'b1);
  endtask

  // After done or error the block swallows everything
  task automatic test_ignored_tail();
    repeat (6) send_req(8'($urandom), 1'b0);
    send_req(8'($urandom), 1'b1);
  endtask

  initial begin
    int r;
    ph = P_RIFF; cnt = 0; word = 0; csize = 0; max_bytes = MAX_DATA_RESET;
    f_fmt = 0; f_ch = 0; f_rate = 0; f_brate = 0; f_align = 0; f_bits = 0;
    low_b = 0; fmt_seen = 0; pad_pend = 0;
    r = $urandom_range(99);
    ending = r < 45 ? END_CLEAN : r < 52 ? END_TRUNC : r < 59 ? END_NO_DATA :
             r < 66 ? END_TOO_BIG : r < 74 ? END_BAD_FMT : r < 82 ? END_SIZE_BAD :
             r < 89 ? END_DATA_FIRST : END_HEADER;
    early_sub = $urandom_range(4);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_max_bytes(32'd0);
    test_riff_header();
    test_chunk_walk();
    write_max_bytes(32'hFFFF_FFFF);
    test_data_chunk();
    test_ignored_tail();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
